[rtl/uyvy2rgb_pkg.sv]
package uyvy2rgb_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 2;
  localparam int unsigned FmtW   = 2;
  localparam int unsigned CoefW  = 18;
  localparam int unsigned ProdW  = ByteW + CoefW;
  localparam int unsigned TermW  = 10;   // signed Q16 product, integer part
  localparam int unsigned SumW   = 11;   // signed channel sum before clamping

  // BT.601 coefficients in Q16
  localparam logic [CoefW-1:0] QY  = 18'd76284;
  localparam logic [CoefW-1:0] QRV = 18'd104595;
  localparam logic [CoefW-1:0] QGU = 18'd25625;
  localparam logic [CoefW-1:0] QGV = 18'd53281;
  localparam logic [CoefW-1:0] QBU = 18'd132252;

  localparam logic [ByteW-1:0] ChromaOfs = 8'd128;
  localparam logic [ByteW-1:0] LumaOfs   = 8'd16;
  localparam logic [ByteW-1:0] ByteMax   = 8'd255;

  localparam logic [CountW-1:0] PixCountOne = 2'd1;
  localparam logic [CountW-1:0] PixCountTwo = 2'd2;

  // code 3 is unused and behaves as UYVY (bit 1 set)
  typedef enum logic [FmtW-1:0] {
    FmtBgraCopy = 2'd0,
    FmtBgraSwap = 2'd1,
    FmtUyvy     = 2'd2
  } fmt_e;

  typedef struct packed {
    logic [ByteW-1:0] c0;
    logic [ByteW-1:0] c1;
    logic [ByteW-1:0] c2;
  } rgb_t;

  // c * x / 65536, truncated toward zero
  function automatic logic signed [TermW-1:0] qmul(input logic [CoefW-1:0] c,
                                                  input logic signed [ByteW:0] x);
    logic [ByteW:0]            neg;
    logic [ByteW-1:0]          mag;
    logic [ProdW-1:0]          prod;
    logic signed [TermW-1:0]   t;
    neg  = -x;
    mag  = x[ByteW] ? neg[ByteW-1:0] : x[ByteW-1:0];
    prod = ProdW'(mag) * ProdW'(c);
    t    = signed'(prod[ProdW-1:16]);
    return x[ByteW] ? -t : t;
  endfunction

  function automatic logic [ByteW-1:0] sat8(input logic signed [SumW-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > signed'(SumW'(ByteMax))) begin
      return ByteMax;
    end
    return v[ByteW-1:0];
  endfunction

  function automatic rgb_t yuv_pixel(input logic signed [ByteW:0] y,
                                     input logic signed [ByteW:0] u,
                                     input logic signed [ByteW:0] v);
    logic signed [TermW-1:0] cy;
    logic signed [SumW-1:0]  r_s;
    logic signed [SumW-1:0]  g_s;
    logic signed [SumW-1:0]  b_s;
    rgb_t                    px;
    cy  = qmul(QY, y);
    r_s = SumW'(cy) + SumW'(qmul(QRV, v));
    g_s = SumW'(cy) - SumW'(qmul(QGU, u)) - SumW'(qmul(QGV, v));
    b_s = SumW'(cy) + SumW'(qmul(QBU, u));
    px.c0 = sat8(r_s);
    px.c1 = sat8(g_s);
    px.c2 = sat8(b_s);
    return px;
  endfunction

endpackage

[rtl/uyvy2rgb_src_if.sv]
interface uyvy2rgb_src_if;
  logic                            valid;
  logic                            ready;
  logic [uyvy2rgb_pkg::ByteW-1:0]  src_byte0;
  logic [uyvy2rgb_pkg::ByteW-1:0]  src_byte1;
  logic [uyvy2rgb_pkg::ByteW-1:0]  src_byte2;
  logic [uyvy2rgb_pkg::ByteW-1:0]  src_byte3;

  modport source (output valid, src_byte0, src_byte1, src_byte2, src_byte3, input ready);
  modport sink   (input valid, src_byte0, src_byte1, src_byte2, src_byte3, output ready);
endinterface

[rtl/uyvy2rgb_pix_if.sv]
interface uyvy2rgb_pix_if;
  logic                             valid;
  logic                             ready;
  logic [uyvy2rgb_pkg::ByteW-1:0]   pix0_chan0;
  logic [uyvy2rgb_pkg::ByteW-1:0]   pix0_chan1;
  logic [uyvy2rgb_pkg::ByteW-1:0]   pix0_chan2;
  logic [uyvy2rgb_pkg::ByteW-1:0]   pix1_chan0;
  logic [uyvy2rgb_pkg::ByteW-1:0]   pix1_chan1;
  logic [uyvy2rgb_pkg::ByteW-1:0]   pix1_chan2;
  logic [uyvy2rgb_pkg::CountW-1:0]  pixel_count;

  modport source (output valid, pix0_chan0, pix0_chan1, pix0_chan2,
                  pix1_chan0, pix1_chan1, pix1_chan2, pixel_count, input ready);
  modport sink   (input valid, pix0_chan0, pix0_chan1, pix0_chan2,
                  pix1_chan0, pix1_chan1, pix1_chan2, pixel_count, output ready);
endinterface

[rtl/uyvy_bgra_to_rgb_pixel_converter.sv]
// Channel  Dir  Handshake      Payload
// src_i    in   valid/ready    src_byte0..3 (one UYVY macropixel or one BGRA word)
// pix_o    out  valid/ready    pix0_chan0..2, pix1_chan0..2, pixel_count
// cfg      in   cfg_we_i       cfg_wdata_i -> pixel_format
//
// One item per clock sustained while pix_o.ready stays high; pix_o.valid is driven
// by the result register, which follows the input register.
// The rate is set by the two-register pipe: input register, then the colour maths
// (constant Q16 multiplies, one add per channel but two subtracts for green,
// and a clamp per channel) into the result register.
// Reset clears both stage valids and sets pixel_format to BGRA copy.
// A stall on pix_o backs up one stage at a time; src_i.ready stays high while
// the input stage is empty or can move on in the same cycle.
module uyvy_bgra_to_rgb_pixel_converter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [uyvy2rgb_pkg::FmtW-1:0]      cfg_wdata_i,
  uyvy2rgb_src_if.sink                       src_i,
  uyvy2rgb_pix_if.source                     pix_o
);

  localparam int unsigned BW = uyvy2rgb_pkg::ByteW;

  // configuration
  logic [uyvy2rgb_pkg::FmtW-1:0] fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= uyvy2rgb_pkg::FmtBgraCopy;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  // handshake control
  logic in_vld_q, out_vld_q;
  logic out_adv, in_adv, src_acc;

  assign out_adv     = !out_vld_q || pix_o.ready;   // result register free next edge
  assign in_adv      = in_vld_q && out_adv;         // input stage moves to result
  assign src_i.ready = !in_vld_q || out_adv;
  assign src_acc     = src_i.valid && src_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (src_i.ready) begin
        in_vld_q <= src_i.valid;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // input register: bytes plus the format they were taken under
  logic [BW-1:0]                 b0_q, b1_q, b2_q, b3_q;
  logic [uyvy2rgb_pkg::FmtW-1:0] in_fmt_q;

  always_ff @(posedge clk_i) begin
    if (src_acc) begin
      b0_q     <= src_i.src_byte0;
      b1_q     <= src_i.src_byte1;
      b2_q     <= src_i.src_byte2;
      b3_q     <= src_i.src_byte3;
      in_fmt_q <= fmt_q;
    end
  end

  // colour maths
  logic signed [BW:0]         u_s, v_s, y0_s, y1_s;
  uyvy2rgb_pkg::rgb_t         yuv0, yuv1;
  uyvy2rgb_pkg::rgb_t         px0_d, px1_d;
  logic [uyvy2rgb_pkg::CountW-1:0] cnt_d;

  assign u_s  = signed'({1'b0, b0_q}) - signed'({1'b0, uyvy2rgb_pkg::ChromaOfs});
  assign v_s  = signed'({1'b0, b2_q}) - signed'({1'b0, uyvy2rgb_pkg::ChromaOfs});
  assign y0_s = signed'({1'b0, b1_q}) - signed'({1'b0, uyvy2rgb_pkg::LumaOfs});
  assign y1_s = signed'({1'b0, b3_q}) - signed'({1'b0, uyvy2rgb_pkg::LumaOfs});

  assign yuv0 = uyvy2rgb_pkg::yuv_pixel(y0_s, u_s, v_s);
  assign yuv1 = uyvy2rgb_pkg::yuv_pixel(y1_s, u_s, v_s);

  always_comb begin
    px1_d = '0;
    unique case (in_fmt_q)
      uyvy2rgb_pkg::FmtBgraCopy: begin
        px0_d = '{c0: b0_q, c1: b1_q, c2: b2_q};
        cnt_d = uyvy2rgb_pkg::PixCountOne;
      end
      uyvy2rgb_pkg::FmtBgraSwap: begin
        px0_d = '{c0: b2_q, c1: b1_q, c2: b0_q};
        cnt_d = uyvy2rgb_pkg::PixCountOne;
      end
      default: begin  // UYVY, and the unused code
        px0_d = yuv0;
        px1_d = yuv1;
        cnt_d = uyvy2rgb_pkg::PixCountTwo;
      end
    endcase
  end

  // result register
  uyvy2rgb_pkg::rgb_t              px0_q, px1_q;
  logic [uyvy2rgb_pkg::CountW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      px0_q <= px0_d;
      px1_q <= px1_d;
      cnt_q <= cnt_d;
    end
  end

  assign pix_o.valid       = out_vld_q;
  assign pix_o.pix0_chan0  = px0_q.c0;
  assign pix_o.pix0_chan1  = px0_q.c1;
  assign pix_o.pix0_chan2  = px0_q.c2;
  assign pix_o.pix1_chan0  = px1_q.c0;
  assign pix_o.pix1_chan1  = px1_q.c1;
  assign pix_o.pix1_chan2  = px1_q.c2;
  assign pix_o.pixel_count = cnt_q;

`ifndef NO_ASSERTIONS
  // an item in the input stage is never dropped while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_adv |=> in_vld_q)
    else $error("input stage item lost during stall");

  // an accepted item always lands in the input stage
  a_acc_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_acc |=> in_vld_q)
    else $error("accepted item not held");

  // a moving input stage always fills the result register
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv |=> out_vld_q)
    else $error("result register missed an item");

  // single-pixel results carry a zero second pixel
  a_pix1_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (cnt_q == uyvy2rgb_pkg::PixCountOne) |-> (px1_q == '0))
    else $error("second pixel not zero in BGRA mode");
`endif

endmodule

[bench/tb_uyvy_bgra_to_rgb_pixel_converter.sv]
`timescale 1ns / 1ps

module tb_uyvy_bgra_to_rgb_pixel_converter;

  localparam int unsigned ByteW = uyvy2rgb_pkg::ByteW;
  localparam int unsigned FmtW  = uyvy2rgb_pkg::FmtW;

  // Unused format code; the block treats it as UYVY because bit 1 is set.
  localparam logic [FmtW-1:0] FmtUnused = 2'd3;

  localparam int MaxGap      = 16;    // longest idle per item, either side
  localparam int ResetCycles = 7;
  localparam int DrainCycles = 4;     // settle time before a register write
  localparam int TailCycles  = 8;     // margin for stray results after the pipe drains
  localparam int StallLimit  = 1000;  // cycles without any handshake

  typedef struct packed {
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
    logic [ByteW-1:0] b3;
  } src_word_t;

  // Field order matches the pix channel: pixel 0, pixel 1, count.
  typedef struct packed {
    uyvy2rgb_pkg::rgb_t              p0;
    uyvy2rgb_pkg::rgb_t              p1;
    logic [uyvy2rgb_pkg::CountW-1:0] count;
  } pix_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and everything the bench drives, all known from time zero.
  // ---------------------------------------------------------------------------
  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [FmtW-1:0]  cfg_wdata = uyvy2rgb_pkg::FmtBgraCopy;
  logic             src_valid = 1'b0;
  src_word_t        src_word  = '0;
  logic             pix_ready = 1'b0;

  always #1 clk_i = ~clk_i;

  uyvy2rgb_src_if src_if ();
  uyvy2rgb_pix_if pix_if ();

  assign src_if.valid     = src_valid;
  assign src_if.src_byte0 = src_word.b0;
  assign src_if.src_byte1 = src_word.b1;
  assign src_if.src_byte2 = src_word.b2;
  assign src_if.src_byte3 = src_word.b3;
  assign pix_if.ready     = pix_ready;

  uyvy_bgra_to_rgb_pixel_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .src_i       (src_if),
    .pix_o       (pix_if)
  );

  // ---------------------------------------------------------------------------
  // Colour conversion predictor.
  // Each Q16 product is taken on the magnitude and the sign put back after the
  // shift, so every term truncates toward zero rather than toward minus
  // infinity. Channel sums are then saturated to a byte.
  // ---------------------------------------------------------------------------
  logic [FmtW-1:0] fmt_model = uyvy2rgb_pkg::FmtBgraCopy;   // mirrors pixel_format

  function automatic int q16_term(input int coef, input int x);
    int mag;
    mag = ((x < 0) ? -x : x) * coef / 65536;
    return (x < 0) ? -mag : mag;
  endfunction

  function automatic logic [ByteW-1:0] clamp_byte(input int v);
    if (v < 0) begin
      return '0;
    end
    if (v > int'(uyvy2rgb_pkg::ByteMax)) begin
      return uyvy2rgb_pkg::ByteMax;
    end
    return ByteW'(v);
  endfunction

  function automatic uyvy2rgb_pkg::rgb_t yuv_to_rgb(input int y, input int u, input int v);
    uyvy2rgb_pkg::rgb_t px;
    int                 luma;
    luma  = q16_term(int'(uyvy2rgb_pkg::QY), y);
    px.c0 = clamp_byte(luma + q16_term(int'(uyvy2rgb_pkg::QRV), v));
    px.c1 = clamp_byte(luma - q16_term(int'(uyvy2rgb_pkg::QGU), u)
                            - q16_term(int'(uyvy2rgb_pkg::QGV), v));
    px.c2 = clamp_byte(luma + q16_term(int'(uyvy2rgb_pkg::QBU), u));
    return px;
  endfunction

  function automatic pix_t convert_word(input src_word_t w, input logic [FmtW-1:0] fmt);
    pix_t r;
    int   u;
    int   v;
    r = '0;   // second pixel stays zero in the BGRA modes
    u = int'(w.b0) - int'(uyvy2rgb_pkg::ChromaOfs);
    v = int'(w.b2) - int'(uyvy2rgb_pkg::ChromaOfs);
    case (fmt)
      uyvy2rgb_pkg::FmtUyvy, FmtUnused: begin
        r.p0    = yuv_to_rgb(int'(w.b1) - int'(uyvy2rgb_pkg::LumaOfs), u, v);
        r.p1    = yuv_to_rgb(int'(w.b3) - int'(uyvy2rgb_pkg::LumaOfs), u, v);
        r.count = uyvy2rgb_pkg::PixCountTwo;
      end
      uyvy2rgb_pkg::FmtBgraSwap: begin
        r.p0    = '{c0: w.b2, c1: w.b1, c2: w.b0};
        r.count = uyvy2rgb_pkg::PixCountOne;
      end
      default: begin
        r.p0    = '{c0: w.b0, c1: w.b1, c2: w.b2};
        r.count = uyvy2rgb_pkg::PixCountOne;
      end
    endcase
    return r;
  endfunction

  function automatic string pix_text(input pix_t p);
    return $sformatf("p0=(%0d,%0d,%0d) p1=(%0d,%0d,%0d) n=%0d",
                     p.p0.c0, p.p0.c1, p.p0.c2, p.p1.c0, p.p1.c1, p.p1.c2, p.count);
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: items wait in word_q; each accepted item is converted at
  // acceptance with the format then in force and its pixels queued in order.
  // After each item the driver idles for a drawn number of cycles; calm
  // stretches draw no idling at all.
  // ---------------------------------------------------------------------------
  src_word_t word_q[$];
  pix_t      converted_q[$];
  int        words_queued = 0;
  int        words_taken  = 0;
  int        errors       = 0;
  int        src_gap;
  logic      src_calm;

  always @(posedge clk_i or negedge rst_ni) begin : src_driver
    logic take;
    if (!rst_ni) begin
      src_valid <= 1'b0;
      src_gap   <= 0;
      src_calm  <= 1'b0;
    end else begin
      take = src_valid && src_if.ready;
      if (take) begin
        converted_q.push_back(convert_word(src_word, fmt_model));
        words_taken <= words_taken + 1;
      end
      if (src_valid && !take) begin
        // held until the block takes it
      end else if (src_gap != 0) begin
        src_valid <= 1'b0;
        src_gap   <= src_gap - 1;
      end else if (word_q.size() != 0) begin
        src_word  <= word_q.pop_front();
        src_valid <= 1'b1;
        src_gap   <= src_calm ? 0 : $urandom_range(0, MaxGap);
        if ($urandom_range(0, 49) == 0) begin
          src_calm <= ~src_calm;
        end
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: every accepted item is checked against the oldest prediction,
  // then ready drops for a drawn number of cycles.
  // ---------------------------------------------------------------------------
  int   pix_stall;
  logic pix_calm;

  always @(posedge clk_i or negedge rst_ni) begin : pix_monitor
    pix_t got;
    pix_t want;
    int   hold;
    if (!rst_ni) begin
      pix_ready <= 1'b0;
      pix_stall <= 0;
      pix_calm  <= 1'b0;
    end else if (pix_if.valid && pix_ready) begin
      got = {pix_if.pix0_chan0, pix_if.pix0_chan1, pix_if.pix0_chan2,
             pix_if.pix1_chan0, pix_if.pix1_chan1, pix_if.pix1_chan2,
             pix_if.pixel_count};
      if (converted_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %s", $time, pix_text(got));
        errors++;
      end else begin
        want = converted_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %s, got %s",
                   $time, pix_text(want), pix_text(got));
          errors++;
        end
      end
      hold = pix_calm ? 0 : $urandom_range(0, MaxGap);
      if ($urandom_range(0, 49) == 0) begin
        pix_calm <= ~pix_calm;
      end
      pix_ready <= (hold == 0);
      pix_stall <= hold;
    end else if (pix_stall != 0) begin
      pix_ready <= (pix_stall == 1);
      pix_stall <= pix_stall - 1;
    end else begin
      pix_ready <= 1'b1;
    end
  end

  // Watchdog: any handshake on either side restarts the count.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((src_valid && src_if.ready) || (pix_if.valid && pix_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("uyvy_bgra_to_rgb_pixel_converter regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_word(input logic [ByteW-1:0] b0, input logic [ByteW-1:0] b1,
                            input logic [ByteW-1:0] b2, input logic [ByteW-1:0] b3);
    word_q.push_back('{b0: b0, b1: b1, b2: b2, b3: b3});
    words_queued++;
  endtask

  task automatic queue_random(input int n);
    repeat (n) begin
      queue_word(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                 ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)));
    end
  endtask

  // Every item taken and every result back.
  task automatic wait_idle();
    while (words_taken != words_queued || converted_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // pixel_format is only changed with the pipe empty.
  task automatic set_format(input logic [FmtW-1:0] fmt);
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= fmt;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    fmt_model = fmt;
  endtask

  initial begin : stimulus
    logic [FmtW-1:0] fmt;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset format is BGRA copy: all-zero, all-one, alternating bits, and an
    // alpha byte that must be ignored.
    queue_word(8'h00, 8'h00, 8'h00, 8'h00);
    queue_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_word(8'h55, 8'hAA, 8'h55, 8'hAA);
    queue_word(8'h01, 8'h80, 8'hFE, 8'h00);
    queue_random(246);

    set_format(uyvy2rgb_pkg::FmtBgraSwap);
    queue_word(8'h00, 8'h00, 8'hFF, 8'h00);
    queue_word(8'hFF, 8'h00, 8'h00, 8'hFF);
    queue_word(8'hAA, 8'h55, 8'h55, 8'h3C);
    queue_word(8'h12, 8'h34, 8'h56, 8'h78);
    queue_random(246);

    set_format(uyvy2rgb_pkg::FmtUyvy);
    queue_word(8'd128, 8'd16,  8'd128, 8'd235);  // black and white, no chroma
    queue_word(8'd0,   8'd0,   8'd0,   8'd0);    // low clamp on red and blue
    queue_word(8'd255, 8'd255, 8'd255, 8'd255);  // high clamp on red and blue
    queue_word(8'd0,   8'd255, 8'd255, 8'd0);
    queue_word(8'd255, 8'd0,   8'd0,   8'd255);
    queue_word(8'd128, 8'd128, 8'd128, 8'd128);  // mid grey
    queue_word(8'd0,   8'd128, 8'd255, 8'd128);
    queue_word(8'd255, 8'd128, 8'd0,   8'd128);
    queue_word(8'd127, 8'd17,  8'd129, 8'd15);   // tiny terms, truncation sign
    queue_word(8'd129, 8'd15,  8'd127, 8'd17);
    queue_random(390);

    // Unused code must behave as UYVY.
    set_format(FmtUnused);
    queue_word(8'd128, 8'd16,  8'd128, 8'd235);
    queue_word(8'd0,   8'd255, 8'd255, 8'd0);
    queue_word(8'd90,  8'd81,  8'd240, 8'd145);
    queue_random(247);

    // Short phases with random formats, switching between them while idle.
    repeat (7) begin
      fmt = FmtW'($urandom_range(0, FmtUnused));
      set_format(fmt);
      queue_random(50);
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("uyvy_bgra_to_rgb_pixel_converter regression: pass");
    end else begin
      $display("uyvy_bgra_to_rgb_pixel_converter regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/uyvy2rgb_pkg.sv
rtl/uyvy2rgb_src_if.sv
rtl/uyvy2rgb_pix_if.sv
rtl/uyvy_bgra_to_rgb_pixel_converter.sv
bench/tb_uyvy_bgra_to_rgb_pixel_converter.sv
